/* rtl/lu48_pkg.sv */
// lu48_pkg: shared types and constants of the 48-bit logical unit
// holds the word, operation and state types; depends on nothing
package lu48_pkg;

  localparam int unsigned WordW   = 48;
  localparam int unsigned CntW    = 6;
  localparam int unsigned ExpW    = 7;
  localparam int unsigned ExpLsb  = 41;
  localparam int unsigned ExpBias = 64;

  typedef logic [WordW-1:0] word_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [ExpW-1:0]  exp_t;

  typedef enum logic [2:0] {
    OP_AND    = 3'd0,
    OP_OR     = 3'd1,
    OP_XOR    = 3'd2,
    OP_CADD   = 3'd3,
    OP_POPADD = 3'd4,
    OP_PACK   = 3'd5,
    OP_UNPACK = 3'd6,
    OP_SHIFT  = 3'd7
  } op_t;

  typedef struct packed {
    word_t acc;
    word_t ext;
  } lu_state_t;

endpackage

/* rtl/logical_unit_48bit_pack_unpack.sv */
// 48-bit logical unit with accumulator and extension register. A request
// carries a 3-bit operation and a 48-bit operand; each accepted request
// produces exactly one result holding the accumulator and extension after
// the operation. The unit takes one request per clock cycle while in_stall
// is low: the request is captured in an input register, and once the result
// register can advance the combinational next-state logic (logic ops,
// end-around carry add, popcount add, pack, unpack and the 96-bit shift)
// updates the accumulator and extension registers, which double as the
// result register. in_stall rises only while the input register holds a
// request and the result register is full and stalled, so a new request
// is still taken while a finished result waits to be collected.
// Shift distance is operand bits 47..41 minus 64: positive shifts right
// with bits leaving the accumulator entering the extension from the top,
// negative shifts left with bits entering the extension from the bottom.
module logical_unit_48bit_pack_unpack (
  input  logic            clk,
  input  logic            rst_n,
  // request channel
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      in_operation,
  input  lu48_pkg::word_t in_operand,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output lu48_pkg::word_t out_accumulator_out,
  output lu48_pkg::word_t out_extension_out
);
  import lu48_pkg::*;

  // input register
  logic      s1_valid_r;
  op_t       s1_op_r;
  word_t     s1_operand_r;

  // result register, which is also the architectural state
  logic      out_valid_r;
  lu_state_t state_r;
  lu_state_t state_nxt;

  logic      advance;

  // result register can take a new value when empty or being collected
  assign advance  = !out_valid_r || !out_stall;
  // input register blocks only when it is full and cannot drain
  assign in_stall = s1_valid_r && !advance;

  lu48_alu u_alu (
    .op      (s1_op_r),
    .operand (s1_operand_r),
    .cur     (state_r),
    .nxt     (state_nxt)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      // accumulator moves only when a request leaves the input register
      if (advance && s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r      <= op_t'(in_operation);
      s1_operand_r <= in_operand;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accumulator_out = state_r.acc;
  assign out_extension_out   = state_r.ext;

endmodule

/* rtl/lu48_bitfield.sv */
// lu48_bitfield: pack (bit extract) and unpack (bit deposit) networks
// depends on lu48_pkg
module lu48_bitfield (
  input  lu48_pkg::word_t acc,
  input  lu48_pkg::word_t mask,
  output lu48_pkg::word_t packed_word,
  output lu48_pkg::word_t unpacked_word
);
  import lu48_pkg::*;

  // number of mask ones strictly above each position
  cnt_t above [WordW];

  always_comb begin
    for (int p = 0; p < WordW; p++) begin
      above[p] = CntW'($countones(mask >> (p + 1)));
    end
  end

  // deposit: the k-th mask one from the top takes acc bit 47-k
  always_comb begin
    for (int p = 0; p < WordW; p++) begin
      unpacked_word[p] = mask[p] & acc[CntW'(WordW - 1) - above[p]];
    end
  end

  // extract: selected bit with k ones above lands in bit 47-k
  always_comb begin
    packed_word = '0;
    for (int j = 0; j < WordW; j++) begin
      for (int p = 0; p < WordW; p++) begin
        if (mask[p] && (above[p] == CntW'(WordW - 1 - j))) begin
          packed_word[j] = packed_word[j] | acc[p];
        end
      end
    end
  end

endmodule

/* rtl/lu48_alu.sv */
// lu48_alu: combinational next-state logic for one request
// depends on lu48_pkg and lu48_bitfield
module lu48_alu (
  input  lu48_pkg::op_t       op,
  input  lu48_pkg::word_t     operand,
  input  lu48_pkg::lu_state_t cur,
  output lu48_pkg::lu_state_t nxt
);
  import lu48_pkg::*;

  word_t             packed_word;
  word_t             unpacked_word;
  word_t             pop_word;
  word_t             add_a;
  logic [WordW:0]    sum;
  word_t             cadd;
  exp_t              expo;
  exp_t              lamt;
  logic [2*WordW-1:0] rsh;
  logic [2*WordW-1:0] lsh;

  lu48_bitfield u_bitfield (
    .acc           (cur.acc),
    .mask          (operand),
    .packed_word   (packed_word),
    .unpacked_word (unpacked_word)
  );

  // end-around carry add, shared by both add operations
  assign pop_word = WordW'($countones(cur.acc));
  assign add_a    = (op == OP_POPADD) ? pop_word : cur.acc;
  assign sum      = {1'b0, add_a} + {1'b0, operand};
  assign cadd     = sum[WordW-1:0] + WordW'(sum[WordW]);

  // shift: exponent at or above the bias shifts right, below shifts left
  assign expo = operand[ExpLsb +: ExpW];
  assign lamt = ExpW'(ExpBias) - expo;
  assign rsh  = {cur.acc, WordW'(0)} >> expo[ExpW-2:0];
  assign lsh  = {WordW'(0), cur.acc} << lamt;

  always_comb begin
    nxt.acc = cur.acc;
    nxt.ext = '0;
    unique case (op)
      OP_AND: begin
        nxt.acc = cur.acc & operand;
      end
      OP_OR: begin
        nxt.acc = cur.acc | operand;
      end
      OP_XOR: begin
        nxt.acc = cur.acc ^ operand;
        nxt.ext = cur.acc;
      end
      OP_CADD, OP_POPADD: begin
        nxt.acc = cadd;
      end
      OP_PACK: begin
        nxt.acc = packed_word;
      end
      OP_UNPACK: begin
        nxt.acc = unpacked_word;
      end
      OP_SHIFT: begin
        if (expo[ExpW-1]) begin
          nxt.acc = rsh[2*WordW-1:WordW];
          nxt.ext = rsh[WordW-1:0];
        end else begin
          nxt.acc = lsh[WordW-1:0];
          nxt.ext = lsh[2*WordW-1:WordW];
        end
      end
      default: begin
        nxt.acc = cur.acc;
        nxt.ext = '0;
      end
    endcase
  end

endmodule

/* rtl/lu48_checker.sv */
// lu48_checker: port-level checks for the 48-bit logical unit
// bound to logical_unit_48bit_pack_unpack; depends on nothing
module lu48_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [47:0] out_accumulator_out,
  input logic [47:0] out_extension_out,
  input logic        out_valid,
  input logic        out_stall
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_accumulator_out)
      && $stable(out_extension_out))
    else $error("stalled result changed");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted request is followed by a valid result on the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("result missing two cycles after request");

  // one request of buffering: a request taken behind a stalled result fills the unit
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && in_valid && !in_stall) ##1 out_stall |-> in_stall)
    else $error("request path not blocked when full");

endmodule

bind logical_unit_48bit_pack_unpack lu48_checker u_lu48_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 100ps
// testbench for logical_unit_48bit_pack_unpack: directed, random and back-pressure requests
// keeps its own accumulator and extension predictor; depends on lu48_pkg and the unit's rtl
module testbench;
  import lu48_pkg::*;

  // give up after this many cycles with no request or result moving
  localparam int StallLimit  = 1000;
  // settling time after the last result, well past the unit's latency
  localparam int DrainCycles = 8;
  localparam word_t AllOnes  = '1;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  logic  [2:0] in_operation;
  word_t in_operand;
  logic  out_valid;
  logic  out_stall;
  word_t out_accumulator_out;
  word_t out_extension_out;

  // predictor copy of the unit's registers
  word_t model_acc;
  word_t model_ext;
  // accumulator/extension pairs still owed by the unit, oldest first
  lu_state_t owed_states[$];

  int error_count;
  int quiet_cycles;
  // both sides idle at random while this is set
  bit gaps_on;
  // receiver holds off for this many cycles, counted down below
  int hold_off_cycles;

  logical_unit_48bit_pack_unpack dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_operand          (in_operand),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accumulator_out (out_accumulator_out),
    .out_extension_out   (out_extension_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("error @%0t: %s", $time, msg);
    error_count++;
  endtask

  // end-around carry: a carry out of bit 47 comes back in at bit 0
  function automatic word_t end_around_add(input word_t a, input word_t b);
    logic [WordW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum[WordW]) begin
      sum = {1'b0, sum[WordW-1:0]} + 1'b1;
    end
    return sum[WordW-1:0];
  endfunction

  // advances the predictor by one request and returns the state the unit should report
  function automatic lu_state_t step_unit_state(input op_t op, input word_t operand);
    word_t             gathered;
    logic [2*WordW-1:0] wide;
    int                src;
    int                places;
    gathered = '0;
    case (op)
      OP_AND: begin
        model_acc = model_acc & operand;
        model_ext = '0;
      end
      OP_OR: begin
        model_acc = model_acc | operand;
        model_ext = '0;
      end
      OP_XOR: begin
        // old accumulator is kept in the extension
        model_ext = model_acc;
        model_acc = model_acc ^ operand;
      end
      OP_CADD: begin
        model_acc = end_around_add(model_acc, operand);
        model_ext = '0;
      end
      OP_POPADD: begin
        model_acc = end_around_add(word_t'($countones(model_acc)), operand);
        model_ext = '0;
      end
      OP_PACK: begin
        // selected bits slide in from the top, so the highest lands in bit 47
        for (int pos = 0; pos < WordW; pos++) begin
          if (operand[pos]) begin
            gathered = {model_acc[pos], gathered[WordW-1:1]};
          end
        end
        model_acc = gathered;
        model_ext = '0;
      end
      OP_UNPACK: begin
        // mask ones from the top take accumulator bits from the top
        src = WordW - 1;
        for (int pos = WordW - 1; pos >= 0; pos--) begin
          if (operand[pos]) begin
            gathered[pos] = model_acc[src];
            src--;
          end
        end
        model_acc = gathered;
        model_ext = '0;
      end
      default: begin
        // shift: positive distance is right through {acc,ext}, negative is left
        // through {ext,acc}; far shifts fall out of the same 96-bit rule
        places = int'(operand[ExpLsb +: ExpW]) - int'(ExpBias);
        if (places == 0) begin
          model_ext = '0;
        end else if (places > 0) begin
          wide = {model_acc, {WordW{1'b0}}} >> places;
          model_acc = wide[2*WordW-1:WordW];
          model_ext = wide[WordW-1:0];
        end else begin
          wide = {{WordW{1'b0}}, model_acc} << (-places);
          model_ext = wide[2*WordW-1:WordW];
          model_acc = wide[WordW-1:0];
        end
      end
    endcase
    return '{acc: model_acc, ext: model_ext};
  endfunction

  // offers one request, holding it steady until taken, then records what it owes
  task automatic send_request(input op_t op, input word_t operand);
    int gap;
    if (gaps_on && $urandom_range(0, 99) < 36) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_operand   <= operand;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    owed_states.push_back(step_unit_state(op, operand));
  endtask

  // operand whose exponent field gives the wanted shift distance
  function automatic word_t shift_operand(input int places);
    word_t w;
    w = word_t'({$urandom, $urandom});
    w[ExpLsb +: ExpW] = exp_t'(places + int'(ExpBias));
    return w;
  endfunction

  // mix of extremes, single bits, sparse and dense masks and plain random words
  function automatic word_t random_operand();
    word_t w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = AllOnes;
      2:       w = word_t'(1) << $urandom_range(0, WordW - 1);
      3:       w = word_t'({$urandom, $urandom} & {$urandom, $urandom}
                           & {$urandom, $urandom});
      4:       w = word_t'({$urandom, $urandom} | {$urandom, $urandom});
      default: w = word_t'({$urandom, $urandom});
    endcase
    return w;
  endfunction

  // receiver: checks each result taken at this edge, then picks next cycle's stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_states.size() == 0) begin
          report_error($sformatf("unexpected result acc=%h ext=%h",
                                 out_accumulator_out, out_extension_out));
        end else begin
          if (out_accumulator_out !== owed_states[0].acc) begin
            report_error($sformatf("accumulator got %h want %h",
                                   out_accumulator_out, owed_states[0].acc));
          end
          if (out_extension_out !== owed_states[0].ext) begin
            report_error($sformatf("extension got %h want %h",
                                   out_extension_out, owed_states[0].ext));
          end
          void'(owed_states.pop_front());
        end
      end
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else if (gaps_on) begin
        out_stall <= ($urandom_range(0, 99) < 36);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: counts cycles in which neither channel moves
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_bitwise_ops();
    send_request(OP_OR,  AllOnes);
    send_request(OP_AND, 48'haaaa_aaaa_aaaa);
    // xor keeps the old accumulator in the extension
    send_request(OP_XOR, AllOnes);
    send_request(OP_AND, '0);
  endtask

  task automatic test_cyclic_add();
    send_request(OP_OR,     AllOnes);
    // all ones plus one carries out and comes back as one
    send_request(OP_CADD,   48'h1);
    send_request(OP_CADD,   AllOnes);
    send_request(OP_POPADD, '0);
    send_request(OP_POPADD, AllOnes);
  endtask

  task automatic test_pack_unpack();
    send_request(OP_OR,     48'hf0f0_f0f0_f0f0);
    send_request(OP_PACK,   AllOnes);
    send_request(OP_PACK,   48'h0000_ffff_0000);
    send_request(OP_PACK,   '0);
    send_request(OP_OR,     48'h8123_4567_89ab);
    send_request(OP_UNPACK, AllOnes);
    send_request(OP_UNPACK, 48'h8000_0000_0001);
  endtask

  task automatic test_shifts();
    send_request(OP_OR,    48'h8123_4567_89ab);
    send_request(OP_SHIFT, shift_operand(0));
    send_request(OP_SHIFT, shift_operand(1));
    send_request(OP_SHIFT, shift_operand(-1));
    send_request(OP_SHIFT, shift_operand(47));
    // far right shift lands the accumulator inside the extension
    send_request(OP_OR,    48'hc0ff_ee12_3457);
    send_request(OP_SHIFT, shift_operand(63));
    // far left shifts, including the 64-place case
    send_request(OP_OR,    48'hc0ff_ee12_3457);
    send_request(OP_SHIFT, shift_operand(-48));
    send_request(OP_OR,    48'hdead_beef_0001);
    send_request(OP_SHIFT, shift_operand(-64));
  endtask

  task automatic test_random_requests(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(op_t'($urandom_range(0, 7)), random_operand());
    end
  endtask

  // receiver holds off while requests keep coming, so the unit fills and stalls its input
  task automatic test_back_pressure();
    hold_off_cycles = 40;
    for (int i = 0; i < 24; i++) begin
      send_request(op_t'($urandom_range(0, 7)), random_operand());
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_AND;
    in_operand      = '0;
    out_stall       = 1'b0;
    model_acc       = '0;
    model_ext       = '0;
    error_count     = 0;
    quiet_cycles    = 0;
    gaps_on         = 1'b1;
    hold_off_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bitwise_ops();
    test_cyclic_add();
    test_pack_unpack();
    test_shifts();
    test_random_requests(150);
    // long stretch with both sides running flat out
    gaps_on = 1'b0;
    test_random_requests(150);
    gaps_on = 1'b1;
    test_back_pressure();
    test_random_requests(200);

    in_valid <= 1'b0;
    while (owed_states.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
